[sv/pca_pkg.sv]
`default_nettype none

package pca_pkg;

    // Field widths of one request and one response
    localparam int OP_W     = 2;
    localparam int PIN_W    = 6;
    localparam int FREQ_W   = 32;
    localparam int RES_W    = 5;
    localparam int CHAN_W   = 4;
    localparam int COUNT_W  = 5;

    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_ANY     = 2'd0;
    localparam op_t OP_NAMED   = 2'd1;
    localparam op_t OP_RELEASE = 2'd2;

    typedef struct packed {
        op_t                operation;
        logic [PIN_W-1:0]   pin;
        logic [FREQ_W-1:0]  frequency;
        logic [RES_W-1:0]   resolution;
        logic [CHAN_W-1:0]  channel_request;
    } item_t;

    typedef struct packed {
        logic               ok;
        logic [CHAN_W-1:0]  channel;
        logic [COUNT_W-1:0] free_count;
    } result_t;

endpackage

`default_nettype wire

[sv/pwm_channel_allocator.sv]
`default_nettype none

// PWM channel allocator. Tracks up to NUM_CHANNELS PWM channels, each with
// a mask of attached pins, a frequency, a resolution and a busy mark.
// Operation 0 returns the lowest channel already holding the pin, or claims
// the lowest free one; operation 1 claims the named channel when it is free,
// returns it when it already holds the pin, or joins it when it is busy with
// matching frequency and resolution; operation 2 detaches the pin from the
// lowest channel holding it and frees that channel once its mask is empty.
// Each transaction yields one response carrying ok, the channel (zero on
// failure) and the count of free channels after the operation. Throughput
// is one transaction per clock while the response side does not stall: the
// channel table is read, decided on and updated between the request
// register and the response register, so the next request already sees the
// update. Reset empties the table at once; no clearing pass is needed.

module pwm_channel_allocator
    import pca_pkg::*;
#(
    parameter int NUM_CHANNELS = 16,
    parameter int PIN_COUNT    = 64
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // request channel
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire logic [OP_W-1:0]     operation,
    input  wire logic [PIN_W-1:0]    pin,
    input  wire logic [FREQ_W-1:0]   frequency,
    input  wire logic [RES_W-1:0]    resolution,
    input  wire logic [CHAN_W-1:0]   channel_request,
    // response channel
    output logic                     res_valid,
    input  wire logic                res_stall,
    output logic                     ok,
    output logic [CHAN_W-1:0]        channel,
    output logic [COUNT_W-1:0]       free_count
);

    item_t   load_item;
    item_t   item;
    logic    item_valid;
    logic    exec;
    result_t result;

    logic    res_valid_reg;
    logic    res_valid_next;
    result_t result_reg;

    assign load_item.operation       = operation;
    assign load_item.pin             = pin;
    assign load_item.frequency       = frequency;
    assign load_item.resolution      = resolution;
    assign load_item.channel_request = channel_request;

    // Request register
    pca_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (req_valid),
        .load_stall (req_stall),
        .load_item  (load_item),
        .item_valid (item_valid),
        .item       (item),
        .take       (exec)
    );

    // A held request executes when the response register is free or drains
    assign exec = item_valid && (!res_valid_reg || !res_stall);

    // Channel table plus combinational decision logic
    pca_table #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .PIN_COUNT    (PIN_COUNT)
    ) u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .exec   (exec),
        .item   (item),
        .result (result)
    );

    // Response register
    assign res_valid_next = exec ? 1'b1 : (res_stall ? res_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            result_reg <= result;
        end
    end

    assign res_valid  = res_valid_reg;
    assign ok         = result_reg.ok;
    assign channel    = result_reg.channel;
    assign free_count = result_reg.free_count;

endmodule

`default_nettype wire

[sv/pca_in_stage.sv]
`default_nettype none

module pca_in_stage
    import pca_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  load_valid,
    output logic       load_stall,
    input  wire item_t load_item,
    output logic       item_valid,
    output item_t      item,
    input  wire logic  take
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    // Refill when empty or when the held item is consumed this cycle
    assign load       = load_valid && (!valid_reg || take);
    assign load_stall = valid_reg && !take;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= load_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

[sv/pca_table.sv]
`default_nettype none

module pca_table
    import pca_pkg::*;
#(
    parameter int NUM_CHANNELS = 16,
    parameter int PIN_COUNT    = 64
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  exec,
    input  wire item_t item,
    output result_t    result
);

    logic [PIN_COUNT-1:0]    mask_reg [NUM_CHANNELS];
    logic [FREQ_W-1:0]       freq_reg [NUM_CHANNELS];
    logic [RES_W-1:0]        res_reg  [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] busy_reg;
    logic [COUNT_W-1:0]      free_reg;
    logic [COUNT_W-1:0]      free_next;

    logic [PIN_COUNT-1:0]    pin_bit;
    logic                    pin_ok;
    logic [NUM_CHANNELS-1:0] hit;
    logic [NUM_CHANNELS-1:0] hit_first;
    logic [NUM_CHANNELS-1:0] free_first;
    logic [NUM_CHANNELS-1:0] req_sel;
    logic [NUM_CHANNELS-1:0] rel_empty;
    logic [NUM_CHANNELS-1:0] claim_v;
    logic [NUM_CHANNELS-1:0] join_v;
    logic [NUM_CHANNELS-1:0] rel_v;
    logic                    any_hit;
    logic                    any_free;
    logic                    req_ok;
    logic                    named_busy;
    logic                    named_hit;
    logic                    named_match;
    logic                    seen_hit;
    logic                    seen_free;
    logic [CHAN_W-1:0]       hit_idx;
    logic [CHAN_W-1:0]       free_idx;
    logic                    ok;
    logic [CHAN_W-1:0]       chan;

    assign pin_ok = {1'b0, item.pin} < (PIN_W+1)'(PIN_COUNT);

    // Per-channel lookups and lowest-index priority picks
    always_comb
    begin
        seen_hit    = 1'b0;
        seen_free   = 1'b0;
        hit_idx     = '0;
        free_idx    = '0;
        named_match = 1'b0;
        for (int j = 0; j < PIN_COUNT; j++)
        begin
            pin_bit[j] = (item.pin == PIN_W'(j));
        end
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            hit[i]        = |(mask_reg[i] & pin_bit);
            rel_empty[i]  = ((mask_reg[i] & ~pin_bit) == '0);
            req_sel[i]    = (item.channel_request == CHAN_W'(i));
            hit_first[i]  = hit[i] && !seen_hit;
            free_first[i] = !busy_reg[i] && !seen_free;
            seen_hit      = seen_hit || hit[i];
            seen_free     = seen_free || !busy_reg[i];
            if (hit_first[i])
            begin
                hit_idx = CHAN_W'(i);
            end
            if (free_first[i])
            begin
                free_idx = CHAN_W'(i);
            end
            if (req_sel[i] && freq_reg[i] == item.frequency
                && res_reg[i] == item.resolution)
            begin
                named_match = 1'b1;
            end
        end
        any_hit    = seen_hit;
        any_free   = seen_free;
        req_ok     = |req_sel;
        named_busy = |(req_sel & busy_reg);
        named_hit  = |(req_sel & hit);
    end

    // Request decode
    always_comb
    begin
        ok        = 1'b0;
        chan      = '0;
        claim_v   = '0;
        join_v    = '0;
        rel_v     = '0;
        free_next = free_reg;
        case (item.operation)
            OP_ANY:
            begin
                if (any_hit)
                begin
                    ok   = 1'b1;
                    chan = hit_idx;
                end
                else if (pin_ok && any_free)
                begin
                    ok        = 1'b1;
                    chan      = free_idx;
                    claim_v   = free_first;
                    free_next = free_reg - COUNT_W'(1);
                end
            end
            OP_NAMED:
            begin
                if (pin_ok && req_ok)
                begin
                    if (!named_busy)
                    begin
                        ok        = 1'b1;
                        claim_v   = req_sel;
                        free_next = free_reg - COUNT_W'(1);
                    end
                    else if (named_hit)
                    begin
                        ok = 1'b1;
                    end
                    else if (named_match)
                    begin
                        ok     = 1'b1;
                        join_v = req_sel;
                    end
                    if (ok)
                    begin
                        chan = item.channel_request;
                    end
                end
            end
            OP_RELEASE:
            begin
                if (any_hit)
                begin
                    ok    = 1'b1;
                    chan  = hit_idx;
                    rel_v = hit_first;
                    if (|(hit_first & rel_empty))
                    begin
                        free_next = free_reg + COUNT_W'(1);
                    end
                end
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
            free_reg <= COUNT_W'(NUM_CHANNELS);
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                mask_reg[i] <= '0;
            end
        end
        else if (exec)
        begin
            free_reg <= free_next;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                if (claim_v[i] || join_v[i])
                begin
                    mask_reg[i] <= mask_reg[i] | pin_bit;
                end
                else if (rel_v[i])
                begin
                    mask_reg[i] <= mask_reg[i] & ~pin_bit;
                end
                if (claim_v[i])
                begin
                    busy_reg[i] <= 1'b1;
                end
                else if (rel_v[i] && rel_empty[i])
                begin
                    busy_reg[i] <= 1'b0;
                end
            end
        end
    end

    // Channel settings: written on claim only, read only while busy
    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                if (claim_v[i])
                begin
                    freq_reg[i] <= item.frequency;
                    res_reg[i]  <= item.resolution;
                end
            end
        end
    end

    assign result.ok         = ok;
    assign result.channel    = chan;
    assign result.free_count = free_next;

endmodule

`default_nettype wire
